[src/hes_pkg.sv]
// ----------------------------------------------------------------------------
// hes_pkg
// Shared types, constants and the arctangent table for the steering block.
// ----------------------------------------------------------------------------
package hes_pkg;

  localparam int POS_W        = 24;
  localparam int ANG_W        = 16;
  localparam int DIFF_W       = 26;
  localparam int VEC_W        = 52;
  localparam int VEC_SCALE    = 24;
  localparam int ZACC_W       = 26;
  localparam int SQ_W         = 49;
  localparam int PROD_W       = 29;
  localparam int GAIN_W       = 12;
  localparam int THR_W        = 15;
  localparam int RAD_W        = 40;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic signed [ZACC_W-1:0] ANGLE_PI = ZACC_W'(8388608);

  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(256);
  localparam logic [THR_W-1:0]  THR_RST  = THR_W'(182);
  localparam logic [RAD_W-1:0]  RAD_RST  = RAD_W'(10486);

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  typedef enum logic [1:0] {
    REG_TURN_GAIN   = 2'd0,
    REG_ALIGN_THR   = 2'd1,
    REG_ARRIVE_RAD  = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ITER,
    BK_FIN,
    BK_MUL,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [THR_W-1:0]  thr;
    logic [RAD_W-1:0]  radius;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic signed [DIFF_W-1:0] x0;
    logic signed [DIFF_W-1:0] y0;
    logic signed [ZACC_W-1:0] z0;
    logic signed [ANG_W-1:0]  hd;
    logic                     zero;
  } entry_t;

  // round(atan(2^-i) * 2^23 / pi)
  function automatic logic signed [ZACC_W-1:0] atan_val(input int idx);
    logic signed [ZACC_W-1:0] v;
    case (idx)
      0:       v = ZACC_W'(2097152);
      1:       v = ZACC_W'(1238021);
      2:       v = ZACC_W'(654136);
      3:       v = ZACC_W'(332050);
      4:       v = ZACC_W'(166669);
      5:       v = ZACC_W'(83416);
      6:       v = ZACC_W'(41718);
      7:       v = ZACC_W'(20860);
      8:       v = ZACC_W'(10430);
      9:       v = ZACC_W'(5215);
      10:      v = ZACC_W'(2608);
      11:      v = ZACC_W'(1304);
      12:      v = ZACC_W'(652);
      13:      v = ZACC_W'(326);
      14:      v = ZACC_W'(163);
      15:      v = ZACC_W'(81);
      16:      v = ZACC_W'(41);
      17:      v = ZACC_W'(20);
      18:      v = ZACC_W'(10);
      19:      v = ZACC_W'(5);
      20:      v = ZACC_W'(3);
      21:      v = ZACC_W'(1);
      22:      v = ZACC_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[src/hes_cfg.sv]
// ----------------------------------------------------------------------------
// hes_cfg
// APB register file: turn gain, align threshold, arrival radius squared.
// ----------------------------------------------------------------------------
module hes_cfg
  import hes_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_TURN_GAIN:  cfg_nxt.gain   = pwdata[GAIN_W-1:0];
        REG_ALIGN_THR:  cfg_nxt.thr    = pwdata[THR_W-1:0];
        REG_ARRIVE_RAD: cfg_nxt.radius = pwdata[RAD_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TURN_GAIN:  prdata = CFG_DATA_W'(cfg_r.gain);
      REG_ALIGN_THR:  prdata = CFG_DATA_W'(cfg_r.thr);
      REG_ARRIVE_RAD: prdata = CFG_DATA_W'(cfg_r.radius);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain   <= GAIN_RST;
      cfg_r.thr    <= THR_RST;
      cfg_r.radius <= RAD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[src/hes_front.sv]
// ----------------------------------------------------------------------------
// hes_front
// Takes input words, forms the target offset and folds the left half plane.
// ----------------------------------------------------------------------------
module hes_front
  import hes_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [ANG_W-1:0] in_heading,
  input  logic signed [POS_W-1:0] in_target_x,
  input  logic signed [POS_W-1:0] in_target_y,
  output logic                    f_valid,
  input  logic                    f_ready,
  output entry_t                  f_entry
);

  logic                     valid_r;
  logic                     valid_nxt;
  entry_t                   entry_r;
  entry_t                   entry_nxt;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic                     take;

  assign in_ready = !valid_r || f_ready;
  assign take     = in_valid && in_ready;
  assign f_valid  = valid_r;
  assign f_entry  = entry_r;

  assign dx = DIFF_W'(in_target_x) - DIFF_W'(in_pos_x);
  assign dy = DIFF_W'(in_target_y) - DIFF_W'(in_pos_y);

  always_comb begin
    entry_nxt.hd   = in_heading;
    entry_nxt.zero = (dx == '0) && (dy == '0);
    if (dx < 0) begin
      entry_nxt.x0 = -dx;
      entry_nxt.y0 = -dy;
      entry_nxt.z0 = (dy >= 0) ? ANGLE_PI : -ANGLE_PI;
    end else begin
      entry_nxt.x0 = dx;
      entry_nxt.y0 = dy;
      entry_nxt.z0 = '0;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (f_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

[src/hes_queue.sv]
// ----------------------------------------------------------------------------
// hes_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module hes_queue
  import hes_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_valid,
  output logic   wr_ready,
  input  entry_t wr_entry,
  output logic   rd_valid,
  input  logic   rd_ready,
  output entry_t rd_entry
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t          mem_r [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r;
  logic [AW-1:0]   rd_ptr_nxt;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;
  logic            push;
  logic            pop;

  assign wr_ready = (cnt_r != CW'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_entry = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

[src/hes_back.sv]
// ----------------------------------------------------------------------------
// hes_back
// Iterative CORDIC bearing, error wrap, gain multiply, flags, output register.
// ----------------------------------------------------------------------------
module hes_back
  import hes_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  entry_t                  q_entry,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ANG_W-1:0] out_heading_error,
  output logic signed [ANG_W-1:0] out_turn_cmd,
  output logic                    out_aligned,
  output logic                    out_arrived
);

  localparam int NST = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int CW  = (NST > 1) ? $clog2(NST) : 1;

  bk_state_t                state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic signed [VEC_W-1:0]  x_r, x_nxt;
  logic signed [VEC_W-1:0]  y_r, y_nxt;
  logic signed [ZACC_W-1:0] z_r, z_nxt;
  logic signed [ANG_W-1:0]  hd_r, hd_nxt;
  logic                     zero_r, zero_nxt;
  logic [SQ_W-1:0]          sqx_r, sqx_nxt;
  logic [SQ_W-1:0]          sqy_r, sqy_nxt;
  logic signed [ANG_W-1:0]  err_r, err_nxt;
  logic                     near_r, near_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     ov_r, ov_nxt;
  logic signed [ANG_W-1:0]  oerr_r, oerr_nxt;
  logic signed [ANG_W-1:0]  oturn_r, oturn_nxt;
  logic                     oal_r, oal_nxt;
  logic                     oar_r, oar_nxt;

  logic signed [VEC_W-1:0]    xs, ys;
  logic signed [ZACC_W-1:0]   zr;
  logic signed [2*DIFF_W-1:0] px, py;
  logic signed [PROD_W-1:0]   sh;
  logic signed [ANG_W:0]      e17;
  logic [ANG_W:0]             mag;
  logic [SQ_W:0]              dsq;

  assign q_ready           = (state_r == BK_IDLE);
  assign out_valid         = ov_r;
  assign out_heading_error = oerr_r;
  assign out_turn_cmd      = oturn_r;
  assign out_aligned       = oal_r;
  assign out_arrived       = oar_r;

  assign xs   = x_r >>> cnt_r;
  assign ys   = y_r >>> cnt_r;
  assign zr   = (z_r + ZACC_W'(128)) >>> 8;
  assign px   = q_entry.x0 * q_entry.x0;
  assign py   = q_entry.y0 * q_entry.y0;
  assign sh   = prod_r >>> 8;
  assign e17  = (ANG_W+1)'(err_r);
  assign mag  = (e17 < 0) ? $unsigned(-e17) : $unsigned(e17);
  assign dsq  = (SQ_W+1)'(sqx_r) + (SQ_W+1)'(sqy_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    hd_nxt    = hd_r;
    zero_nxt  = zero_r;
    sqx_nxt   = sqx_r;
    sqy_nxt   = sqy_r;
    err_nxt   = err_r;
    near_nxt  = near_r;
    prod_nxt  = prod_r;
    ov_nxt    = ov_r;
    oerr_nxt  = oerr_r;
    oturn_nxt = oturn_r;
    oal_nxt   = oal_r;
    oar_nxt   = oar_r;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          x_nxt     = VEC_W'(q_entry.x0) <<< VEC_SCALE;
          y_nxt     = VEC_W'(q_entry.y0) <<< VEC_SCALE;
          z_nxt     = q_entry.z0;
          hd_nxt    = q_entry.hd;
          zero_nxt  = q_entry.zero;
          sqx_nxt   = px[SQ_W-1:0];
          sqy_nxt   = py[SQ_W-1:0];
          cnt_nxt   = '0;
          state_nxt = BK_ITER;
        end
      end
      BK_ITER: begin
        if (y_r >= 0) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + atan_val(int'(cnt_r));
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - atan_val(int'(cnt_r));
        end
        if (cnt_r == CW'(NST - 1)) begin
          state_nxt = BK_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      BK_FIN: begin
        err_nxt   = zero_r ? '0 : (zr[ANG_W-1:0] - hd_r);
        near_nxt  = dsq < (SQ_W+1)'(cfg.radius);
        state_nxt = BK_MUL;
      end
      BK_MUL: begin
        prod_nxt  = PROD_W'($signed({1'b0, cfg.gain})) * PROD_W'(err_r);
        state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt   = 1'b1;
          oerr_nxt = err_r;
          if (sh > PROD_W'(32767)) begin
            oturn_nxt = 16'sh7FFF;
          end else if (sh < -PROD_W'(32768)) begin
            oturn_nxt = 16'sh8000;
          end else begin
            oturn_nxt = sh[ANG_W-1:0];
          end
          oal_nxt   = mag < (ANG_W+1)'(cfg.thr);
          oar_nxt   = near_r;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    hd_r    <= hd_nxt;
    zero_r  <= zero_nxt;
    sqx_r   <= sqx_nxt;
    sqy_r   <= sqy_nxt;
    err_r   <= err_nxt;
    near_r  <= near_nxt;
    prod_r  <= prod_nxt;
    oerr_r  <= oerr_nxt;
    oturn_r <= oturn_nxt;
    oal_r   <= oal_nxt;
    oar_r   <= oar_nxt;
  end

endmodule

[src/heading_error_steering.sv]
// ----------------------------------------------------------------------------
// heading_error_steering
// Proportional steering toward a target point from position and heading.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word: position, heading and
// target. Result channel (out_valid/out_ready) gives one word per input:
// wrapped heading error, saturated turn command, aligned and arrived flags.
// Registers (APB, 64-bit data, byte address 8*i): turn gain, align
// threshold, squared arrival radius.
// A front stage forms the offset and folds the left half plane into a
// two-entry queue; the back runs one CORDIC stage per cycle.
// The back takes a word only in BK_IDLE and finishes it before taking the
// next, since the CORDIC stage is shared. An accepted word passes the front
// register, the queue, then back states IDLE, ITER, FIN, MUL and DONE.
// Input words keep being taken into the queue while the back is busy or a
// result waits; a stalled receiver holds the result and then backs up the
// queue and in_ready. Synchronous reset empties the pipe and restores the
// register reset values.
// ----------------------------------------------------------------------------
module heading_error_steering
  import hes_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [ANG_W-1:0] in_heading,
  input  logic signed [POS_W-1:0] in_target_x,
  input  logic signed [POS_W-1:0] in_target_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ANG_W-1:0] out_heading_error,
  output logic signed [ANG_W-1:0] out_turn_cmd,
  output logic                    out_aligned,
  output logic                    out_arrived,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready
);

  cfg_t   cfg;
  logic   f_valid;
  logic   f_ready;
  entry_t f_entry;
  logic   q_valid;
  logic   q_ready;
  entry_t q_entry;

  hes_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hes_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_heading  (in_heading),
    .in_target_x (in_target_x),
    .in_target_y (in_target_y),
    .f_valid     (f_valid),
    .f_ready     (f_ready),
    .f_entry     (f_entry)
  );

  hes_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_entry (f_entry),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_entry (q_entry)
  );

  hes_back #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_entry           (q_entry),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_heading_error (out_heading_error),
    .out_turn_cmd      (out_turn_cmd),
    .out_aligned       (out_aligned),
    .out_arrived       (out_arrived)
  );

endmodule

[src/hes_checker.sv]
// ----------------------------------------------------------------------------
// hes_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hes_checker
  import hes_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [ANG_W-1:0] out_heading_error,
  input logic signed [ANG_W-1:0] out_turn_cmd,
  input logic                    out_aligned,
  input logic                    out_arrived
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_heading_error) &&
      $stable(out_turn_cmd) && $stable(out_aligned) && $stable(out_arrived))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_zero_turn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_heading_error == 16'sd0 |-> out_turn_cmd == 16'sd0)
    else $error("turn command nonzero for zero error");

  a_neg_turn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_heading_error[ANG_W-1] |->
      out_turn_cmd[ANG_W-1] || out_turn_cmd == 16'sd0)
    else $error("turn command sign against error");

  a_pi_unaligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_heading_error == 16'sh8000 |-> !out_aligned)
    else $error("aligned set at error of minus pi");

endmodule

bind heading_error_steering hes_checker u_hes_checker (.*);
